### rtl/irpw_pkg.sv
// Shared types and constants for the infrared pulse-width code receiver.
package irpw_pkg;

  localparam int CFG_W                = 14;
  localparam int CFG_IDX_W            = 1;
  localparam int CODE_W               = 8;
  localparam int COUNT_W              = 3;
  localparam int COUNTER_BITS_DEFAULT = 14;

  localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = 1'b1;

  localparam logic [CFG_W-1:0] ONE_THRESHOLD_RESET = 14'd27;
  localparam logic [CFG_W-1:0] TIMEOUT_RESET       = 14'd8125;

  // Pulses 0..3 carry an even code bit in their low run, 1..4 an odd one in their high run.
  localparam logic [COUNT_W-1:0] CODE_BIT_PULSES = 3'd4;
  localparam logic [COUNT_W-1:0] CODE_PULSES_LO  = 3'd4;
  localparam logic [COUNT_W-1:0] CODE_PULSES_HI  = 3'd5;
  localparam logic [COUNT_W-1:0] PULSE_LIMIT     = 3'd6;

  typedef struct packed {
    logic               frame_active;
    logic               measuring_low;
    logic [COUNT_W-1:0] pulse_index;
    logic [CODE_W-1:0]  code_bits;
  } irpw_ctl_t;

  typedef struct packed {
    logic               fire;
    logic [CODE_W-1:0]  code;
    logic [COUNT_W-1:0] count;
  } irpw_res_t;

endpackage

### rtl/irpw_step.sv
// Per-sample next-state and result logic of the pulse-width decoder.
module irpw_step
  import irpw_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
  input  irpw_ctl_t               ctl,
  input  logic [COUNTER_BITS-1:0] run_cnt,
  input  logic                    pin_level,
  input  logic [CFG_W-1:0]        one_threshold,
  input  logic [CFG_W-1:0]        timeout,
  output irpw_ctl_t               ctl_nxt,
  output logic [COUNTER_BITS-1:0] run_nxt,
  output irpw_res_t               res
);

  localparam int CMP_W = (COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W;
  localparam logic [COUNTER_BITS-1:0] RUN_ONE = COUNTER_BITS'(1);
  localparam logic [COUNTER_BITS-1:0] RUN_MAX = {COUNTER_BITS{1'b1}};

  logic [2:0] even_pos;
  logic [2:0] odd_pos;
  logic       over_thr;

  assign even_pos = {ctl.pulse_index[1:0], 1'b0};
  assign odd_pos  = 3'(({1'b0, ctl.pulse_index} << 1) - 4'd1);
  assign over_thr = CMP_W'(run_cnt) > CMP_W'(one_threshold);

  always_comb begin
    ctl_nxt = ctl;
    run_nxt = run_cnt;
    res     = '0;
    if (!ctl.frame_active) begin
      // open a frame on the first low sample
      if (!pin_level) begin
        ctl_nxt.frame_active  = 1'b1;
        ctl_nxt.measuring_low = 1'b1;
        ctl_nxt.pulse_index   = '0;
        ctl_nxt.code_bits     = '0;
        run_nxt               = RUN_ONE;
      end
    end else begin
      if (ctl.measuring_low == !pin_level) begin
        if (run_cnt != RUN_MAX) begin
          run_nxt = run_cnt + RUN_ONE;
        end
      end else if (ctl.measuring_low) begin
        if (ctl.pulse_index < CODE_BIT_PULSES && over_thr) begin
          ctl_nxt.code_bits = ctl.code_bits | (CODE_W'(1) << even_pos);
        end
        ctl_nxt.pulse_index = ctl.pulse_index + 3'd1;
        if (ctl_nxt.pulse_index == PULSE_LIMIT) begin
          // too many pulses: end with an empty result
          res.fire = 1'b1;
        end else begin
          ctl_nxt.measuring_low = 1'b0;
          run_nxt               = RUN_ONE;
        end
      end else begin
        if (ctl.pulse_index != '0 && ctl.pulse_index <= CODE_BIT_PULSES && over_thr) begin
          ctl_nxt.code_bits = ctl.code_bits | (CODE_W'(1) << odd_pos);
        end
        ctl_nxt.measuring_low = 1'b1;
        run_nxt               = RUN_ONE;
      end

      if (!res.fire && ctl_nxt.pulse_index != '0 && CMP_W'(run_nxt) >= CMP_W'(timeout)) begin
        res.fire  = 1'b1;
        res.count = ctl_nxt.pulse_index;
        if (ctl_nxt.pulse_index == CODE_PULSES_LO || ctl_nxt.pulse_index == CODE_PULSES_HI) begin
          res.code = ctl_nxt.code_bits;
        end
      end

      if (res.fire) begin
        ctl_nxt.frame_active  = 1'b0;
        ctl_nxt.measuring_low = 1'b0;
        run_nxt               = '0;
      end
    end
  end

endmodule

### rtl/ir_pulse_width_code_receiver.sv
// Top level of the infrared pulse-width code receiver.
//
// Usage:
//   Input channel: one sampled receiver level per transfer (in_pin_level,
//   1 high, 0 low) under in_valid / in_stall. While idle, a low sample opens
//   a frame; alternating low and high runs are then timed in samples.
//   Result channel: one transfer per finished frame, carrying the decoded
//   eight-bit code and the count of completed pulses.
//   Configuration: cfg_we writes register cfg_index (0 one threshold,
//   1 timeout) with cfg_wdata; write only while no frame is in progress.
// Timing:
//   One sample per cycle sustained while out_stall is low. A sample is held
//   in the input register, where one pass of the step logic updates the
//   frame state and loads the result register, so the result of the frame's
//   last sample shows on out_valid from the result register behind it.
// Reset and stall:
//   Reset returns to idle with the default threshold and timeout. While a
//   result waits under out_stall, one more sample is still taken into the
//   input register; only then does in_stall rise.
module ir_pulse_width_code_receiver
  import irpw_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_pin_level,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CODE_W-1:0]    out_player_code,
  output logic [COUNT_W-1:0]   out_pulse_count,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // configuration registers
  logic [CFG_W-1:0] one_thr_r;
  logic [CFG_W-1:0] timeout_r;

  // input register
  logic s1_vld_r;
  logic s1_pin_r;

  // frame state
  irpw_ctl_t               ctl_r;
  irpw_ctl_t               ctl_nxt;
  logic [COUNTER_BITS-1:0] run_r;
  logic [COUNTER_BITS-1:0] run_nxt;
  irpw_res_t               res;

  // result register
  logic               out_vld_r;
  logic [CODE_W-1:0]  out_code_r;
  logic [COUNT_W-1:0] out_count_r;

  logic advance;

  // process the held sample whenever the result register has room
  assign advance  = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && out_vld_r && out_stall;

  assign out_valid       = out_vld_r;
  assign out_player_code = out_code_r;
  assign out_pulse_count = out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_thr_r <= ONE_THRESHOLD_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ONE_THRESHOLD: one_thr_r <= cfg_wdata;
        REG_TIMEOUT:       timeout_r <= cfg_wdata;
      endcase
    end
  end

  irpw_step #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_step (
    .ctl          (ctl_r),
    .run_cnt      (run_r),
    .pin_level    (s1_pin_r),
    .one_threshold(one_thr_r),
    .timeout      (timeout_r),
    .ctl_nxt      (ctl_nxt),
    .run_nxt      (run_nxt),
    .res          (res)
  );

  // input register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_pin_r <= in_pin_level;
    end
  end

  // frame state: advance once per processed sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
      run_r <= '0;
    end else if (advance) begin
      ctl_r <= ctl_nxt;
      run_r <= run_nxt;
    end
  end

  // result register: load on a finished frame, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && res.fire) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.fire) begin
      out_code_r  <= res.code;
      out_count_r <= res.count;
    end
  end

`ifndef SYNTHESIS
  a_code_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_count_r == CODE_PULSES_LO || out_count_r == CODE_PULSES_HI ||
                   out_code_r == '0))
    else $error("nonzero code with invalid pulse count");

  a_idle_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl_r.frame_active |-> run_r == '0)
    else $error("run counter not cleared while idle");

  a_fire_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.fire) |-> ctl_r.frame_active)
    else $error("result produced outside a frame");

  a_fire_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.fire) |=> out_vld_r && out_count_r == $past(res.count))
    else $error("finished frame not presented on result channel");
`endif

endmodule
